/* hdl/sharpen_convolution_rgba_assert.svh */
// assertion macros for the sharpen convolution block
// clk and rst_n are taken from the scope where a macro is used
`ifndef SHARPEN_CONVOLUTION_RGBA_ASSERT_SVH
`define SHARPEN_CONVOLUTION_RGBA_ASSERT_SVH

// checked outside of reset only
`define SHCONV_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SHCONV_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/shconv_pkg.sv */
// ----------------------------------------------------------------------------
// shconv_pkg
// shared types, constants and kernel weights of the sharpen convolution block
// ----------------------------------------------------------------------------
`default_nettype none

package shconv_pkg;

  localparam int LANES  = 4;
  localparam int LANE_W = 8;
  localparam int PIX_W  = LANES * LANE_W;
  localparam int KW     = 6;   // signed kernel weight
  localparam int ACCW   = 15;  // signed per-lane accumulator
  localparam int TAP_W  = 3;   // tap column / row index
  localparam int CFG_W  = 9;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRONG_MODE  = 2'd2;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 9'd256;

  // commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  // kernel geometry
  localparam logic [1:0]       RAD_SOFT      = 2'd2;
  localparam logic [1:0]       RAD_STRONG    = 2'd1;
  localparam logic [TAP_W-1:0] SPAN_SOFT     = 3'd4;
  localparam logic [TAP_W-1:0] SPAN_STRONG   = 3'd2;
  localparam logic [TAP_W-1:0] CENTER_SOFT   = 3'd2;
  localparam logic [TAP_W-1:0] CENTER_STRONG = 3'd1;

  // kernel weights
  localparam logic signed [KW-1:0] W_OUTER       = -6'sd1;
  localparam logic signed [KW-1:0] W_SOFT_INNER  = 6'sd2;
  localparam logic signed [KW-1:0] W_SOFT_CENTER = 6'sd16;
  localparam logic signed [KW-1:0] W_STRONG_CTR  = 6'sd9;

  localparam int SOFT_SHIFT = 4;
  localparam logic signed [ACCW-1:0] LANE_MAX = 15'sd255;

  typedef logic signed [ACCW-1:0] shconv_acc_t;

  // one tap issued by the walker
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic signed [KW-1:0] weight;
  } shconv_tap_t;

  function automatic logic signed [KW-1:0] shconv_tap_weight(
    input logic [TAP_W-1:0] dx,
    input logic [TAP_W-1:0] dy,
    input logic             strong_en
  );
    logic inner_x;
    logic inner_y;
    logic signed [KW-1:0] wgt;
    inner_x = (dx >= 3'd1) && (dx <= 3'd3);
    inner_y = (dy >= 3'd1) && (dy <= 3'd3);
    if (strong_en) begin
      wgt = ((dx == CENTER_STRONG) && (dy == CENTER_STRONG)) ? W_STRONG_CTR : W_OUTER;
    end else if ((dx == CENTER_SOFT) && (dy == CENTER_SOFT)) begin
      wgt = W_SOFT_CENTER;
    end else if (inner_x && inner_y) begin
      wgt = W_SOFT_INNER;
    end else begin
      wgt = W_OUTER;
    end
    return wgt;
  endfunction

endpackage

`default_nettype wire

/* hdl/sharpen_convolution_rgba.sv */
// ----------------------------------------------------------------------------
// sharpen_convolution_rgba
// RGBA8 sharpening filter with wrap-around edges over a stored frame
// ----------------------------------------------------------------------------
// An image of image_width x image_height pixels is loaded in raster order by
// load transactions (command 0); loads beyond the pixel count are dropped.
// Once every pixel is in, each emit transaction (command 1) returns the next
// filtered pixel in raster order, with last_pixel set on the final one, after
// which both positions return to zero for the next image. An emit before the
// frame is complete, or a stray emit, returns nothing. Each byte lane is
// filtered on its own: soft mode is a 5x5 kernel (outer ring -1, inner ring
// 2, center 16, sum divided by 16), strong mode a 3x3 kernel (-1 with center
// 9); negative sums give 0 and results saturate at 255. Sizes are clamped to
// 1..MAX_WIDTH and 1..MAX_HEIGHT. The user must write configuration only
// while idle; the block itself does not enforce this. An emit reads its taps
// one per cycle through the single port of the frame store into one shared
// four-lane MAC. The first emit after a width write also recomputes its
// column and row with a serial divider. A finished pixel waits in the output
// register; the next emit completes only after it has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sharpen_convolution_rgba import shconv_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration port
  input  wire logic                 cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // input transactions
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_command,
  input  wire logic [PIX_W-1:0]     in_pixel_in,
  // result transactions
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [PIX_W-1:0]     out_pixel_out,
  output logic                      out_last_pixel
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);       // frame store address
  localparam int PW    = $clog2(DEPTH + 1);   // positions and pixel count
  localparam int DW    = $clog2(MAX_WIDTH + 1);
  localparam int HD    = $clog2(MAX_HEIGHT + 1);
  localparam int XCW   = $clog2(MAX_WIDTH);
  localparam int YCW   = $clog2(MAX_HEIGHT);
  localparam int XW    = (DW > CFG_W) ? DW : CFG_W;
  localparam int YW    = (HD > CFG_W) ? HD : CFG_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECIDE = 7'b0000010,
    ST_DIVIDE = 7'b0000100,
    ST_LAUNCH = 7'b0001000,
    ST_WALK   = 7'b0010000,
    ST_DRAIN  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [CFG_W-1:0] width_cfg_r;
  logic [CFG_W-1:0] height_cfg_r;
  logic             strong_r;
  logic [XW-1:0]    w_ext;
  logic [YW-1:0]    h_ext;
  logic [DW-1:0]    w_use;
  logic [HD-1:0]    h_use;
  logic [DW+HD-1:0] area;
  logic [PW-1:0]    total_r;

  // held transaction
  logic             cmd_r;
  logic [PIX_W-1:0] pix_r;

  // positions
  logic [PW-1:0]  load_pos_r;
  logic [PW-1:0]  emit_pos_r;
  logic [XCW-1:0] emit_x_r;
  logic [YCW-1:0] emit_y_r;
  logic           coord_ok_r;   // emit_x/emit_y match emit_pos for the current width

  // result register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_last_r;

  // datapath links
  logic             load_room;
  logic             emit_ok;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [PIX_W-1:0] mem_rdata;
  logic [AW-1:0]    walk_addr;
  shconv_tap_t      tap;
  logic             div_start;
  logic             div_done;
  logic [PW-1:0]    div_quo;
  logic [DW-1:0]    div_rem;
  logic [PIX_W-1:0] mac_result;
  logic             out_free;
  logic             finish_fire;
  logic             is_last;

  // clamp sizes to the store geometry, zero counts as one
  assign w_ext = XW'(width_cfg_r);
  assign h_ext = YW'(height_cfg_r);
  assign w_use = (w_ext == '0) ? DW'(1) :
                 (w_ext > XW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(w_ext);
  assign h_use = (h_ext == '0) ? HD'(1) :
                 (h_ext > YW'(MAX_HEIGHT)) ? HD'(MAX_HEIGHT) : HD'(h_ext);
  assign area  = w_use * h_use;

  always_ff @(posedge clk) begin
    total_r <= PW'(area);
  end

  assign load_room   = load_pos_r < total_r;
  assign emit_ok     = !load_room && (emit_pos_r < total_r);
  assign out_free    = !out_valid_r || !out_stall;
  assign finish_fire = (state_r == ST_FINISH) && out_free;
  assign is_last     = emit_pos_r == (total_r - PW'(1));

  assign mem_we    = (state_r == ST_DECIDE) && (cmd_r == CMD_LOAD) && load_room;
  assign mem_addr  = (state_r == ST_DECIDE) ? AW'(load_pos_r) : walk_addr;
  assign div_start = (state_r == ST_DECIDE) && (cmd_r == CMD_EMIT) && emit_ok &&
                     !coord_ok_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if ((cmd_r == CMD_EMIT) && emit_ok) begin
          state_nxt = coord_ok_r ? ST_LAUNCH : ST_DIVIDE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) state_nxt = ST_LAUNCH;
      end
      ST_LAUNCH: state_nxt = ST_WALK;
      ST_WALK: begin
        if (tap.valid && tap.last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      cmd_r <= in_command;
      pix_r <= in_pixel_in;
    end
  end

  // positions, configuration and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r   <= '0;
      emit_pos_r   <= '0;
      emit_x_r     <= '0;
      emit_y_r     <= '0;
      coord_ok_r   <= 1'b1;
      out_valid_r  <= 1'b0;
      width_cfg_r  <= CFG_DIM_RESET;
      height_cfg_r <= CFG_DIM_RESET;
      strong_r     <= 1'b0;
    end else begin
      if (mem_we) begin
        load_pos_r <= load_pos_r + PW'(1);
      end

      if ((state_r == ST_DIVIDE) && div_done) begin
        emit_x_r   <= XCW'(div_rem);
        emit_y_r   <= YCW'(div_quo);
        coord_ok_r <= 1'b1;
      end

      if (finish_fire) begin
        if (is_last) begin
          // end of image, ready for the next frame
          load_pos_r <= '0;
          emit_pos_r <= '0;
          emit_x_r   <= '0;
          emit_y_r   <= '0;
          coord_ok_r <= 1'b1;
        end else begin
          emit_pos_r <= emit_pos_r + PW'(1);
          if (emit_x_r == XCW'(w_use - DW'(1))) begin
            emit_x_r <= '0;
            emit_y_r <= emit_y_r + YCW'(1);
          end else begin
            emit_x_r <= emit_x_r + XCW'(1);
          end
        end
      end

      if (finish_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_write_en) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: begin
            width_cfg_r <= cfg_data;
            // column/row must be rederived from the raster position
            coord_ok_r  <= 1'b0;
          end
          CFG_IMAGE_HEIGHT: height_cfg_r <= cfg_data;
          CFG_STRONG_MODE:  strong_r     <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (finish_fire) begin
      out_pixel_r <= mac_result;
      out_last_r  <= is_last;
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pixel_r;
  assign out_last_pixel = out_last_r;

  shconv_frame_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (tap.valid),
    .addr  (mem_addr),
    .wdata (pix_r),
    .rdata (mem_rdata)
  );

  shconv_div #(
    .NW  (PW),
    .DVW (DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (emit_pos_r),
    .divisor   (w_use),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  shconv_tap_walker #(
    .XCW (XCW),
    .YCW (YCW),
    .DW  (DW),
    .HD  (HD),
    .AW  (AW)
  ) u_tap_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == ST_LAUNCH),
    .x0        (emit_x_r),
    .y0        (emit_y_r),
    .w         (w_use),
    .h         (h_use),
    .strong_en (strong_r),
    .tap       (tap),
    .addr      (walk_addr)
  );

  shconv_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (state_r == ST_DECIDE),
    .tap       (tap),
    .rd_data   (mem_rdata),
    .strong_en (strong_r),
    .result    (mac_result)
  );

endmodule

`default_nettype wire

/* hdl/shconv_frame_store.sv */
// ----------------------------------------------------------------------------
// shconv_frame_store
// single-port pixel memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module shconv_frame_store import shconv_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [PIX_W-1:0] wdata,
  output logic      [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/shconv_div.sv */
// ----------------------------------------------------------------------------
// shconv_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module shconv_div #(
  parameter int NW  = 17,
  parameter int DVW = 9
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [NW-1:0]  dividend,
  input  wire logic [DVW-1:0] divisor,
  output logic                done,
  output logic      [NW-1:0]  quotient,
  output logic      [DVW-1:0] remainder
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] dvd_r;
  logic [NW-1:0] quo_r;
  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] dvs_r;
  logic [DVW:0]  trial;
  logic          fits;

  assign trial = {rem_r, dvd_r[NW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      quo_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[NW-2:0], 1'b0};
      quo_r <= {quo_r[NW-2:0], fits};
      rem_r <= fits ? DVW'(trial - {1'b0, dvs_r}) : trial[DVW-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

/* hdl/shconv_mac.sv */
// ----------------------------------------------------------------------------
// shconv_mac
// four-lane multiply-accumulate shared by all taps, with clamp and scale
// ----------------------------------------------------------------------------
`default_nettype none

module shconv_mac import shconv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             clear,
  input  wire shconv_tap_t      tap,
  input  wire logic [PIX_W-1:0] rd_data,
  input  wire logic             strong_en,
  output logic      [PIX_W-1:0] result
);

  shconv_tap_t tap_q_r;
  shconv_acc_t acc_r  [LANES];
  shconv_acc_t prod   [LANES];
  shconv_acc_t scaled [LANES];

  // weight lines up with the registered memory data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_q_r <= '0;
    end else begin
      tap_q_r <= tap;
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod[i] = $signed({1'b0, rd_data[i*LANE_W +: LANE_W]}) * tap_q_r.weight;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (clear) begin
        acc_r[i] <= '0;
      end else if (tap_q_r.valid) begin
        acc_r[i] <= acc_r[i] + prod[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (acc_r[i][ACCW-1]) begin
        scaled[i] = '0;
      end else if (strong_en) begin
        scaled[i] = acc_r[i];
      end else begin
        scaled[i] = acc_r[i] >>> SOFT_SHIFT;
      end
      result[i*LANE_W +: LANE_W] = (scaled[i] > LANE_MAX) ? {LANE_W{1'b1}}
                                                          : scaled[i][LANE_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hdl/shconv_tap_walker.sv */
// ----------------------------------------------------------------------------
// shconv_tap_walker
// steps through the kernel window, one frame store address per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module shconv_tap_walker import shconv_pkg::*; #(
  parameter int XCW = 8,
  parameter int YCW = 8,
  parameter int DW  = 9,
  parameter int HD  = 9,
  parameter int AW  = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [XCW-1:0] x0,
  input  wire logic [YCW-1:0] y0,
  input  wire logic [DW-1:0]  w,
  input  wire logic [HD-1:0]  h,
  input  wire logic           strong_en,
  output shconv_tap_t         tap,
  output logic      [AW-1:0]  addr
);

  typedef enum logic [3:0] {
    W_IDLE = 4'b0001,
    W_BACK = 4'b0010,
    W_BASE = 4'b0100,
    W_RUN  = 4'b1000
  } walk_state_t;

  walk_state_t state_r, state_nxt;

  logic [1:0]       cnt_r;
  logic [XCW-1:0]   ix_r;
  logic [XCW-1:0]   ix0_r;
  logic [YCW-1:0]   iy_r;
  logic [AW-1:0]    base_r;
  logic [TAP_W-1:0] dx_r;
  logic [TAP_W-1:0] dy_r;
  logic [XCW-1:0]   x_max;
  logic [YCW-1:0]   y_max;
  logic [1:0]       rad;
  logic [TAP_W-1:0] span;
  logic [YCW+DW-1:0] row_prod;
  logic             run;
  logic             last_tap;

  assign x_max    = XCW'(w - DW'(1));
  assign y_max    = YCW'(h - HD'(1));
  assign rad      = strong_en ? RAD_STRONG : RAD_SOFT;
  assign span     = strong_en ? SPAN_STRONG : SPAN_SOFT;
  assign row_prod = iy_r * w;
  assign run      = (state_r == W_RUN);
  assign last_tap = run && (dx_r == span) && (dy_r == span);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      W_IDLE: if (start) state_nxt = W_BACK;
      W_BACK: if (cnt_r == 2'd1) state_nxt = W_BASE;
      W_BASE: state_nxt = W_RUN;
      W_RUN:  if (last_tap) state_nxt = W_IDLE;
      default: state_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      W_IDLE: begin
        if (start) begin
          ix_r  <= x0;
          iy_r  <= y0;
          cnt_r <= rad;
        end
      end
      // move to the top-left corner of the window, wrapping at the edges
      W_BACK: begin
        ix_r  <= (ix_r == '0) ? x_max : ix_r - XCW'(1);
        iy_r  <= (iy_r == '0) ? y_max : iy_r - YCW'(1);
        cnt_r <= cnt_r - 2'd1;
      end
      W_BASE: begin
        base_r <= AW'(row_prod);
        ix0_r  <= ix_r;
        dx_r   <= '0;
        dy_r   <= '0;
      end
      W_RUN: begin
        if (dx_r == span) begin
          dx_r <= '0;
          dy_r <= dy_r + TAP_W'(1);
          ix_r <= ix0_r;
          if (iy_r == y_max) begin
            iy_r   <= '0;
            base_r <= '0;
          end else begin
            iy_r   <= iy_r + YCW'(1);
            base_r <= base_r + AW'(w);
          end
        end else begin
          dx_r <= dx_r + TAP_W'(1);
          ix_r <= (ix_r == x_max) ? '0 : ix_r + XCW'(1);
        end
      end
      default: ;
    endcase
  end

  assign tap.valid  = run;
  assign tap.last   = last_tap;
  assign tap.weight = shconv_tap_weight(dx_r, dy_r, strong_en);
  assign addr       = base_r + AW'(ix_r);

endmodule

`default_nettype wire

/* hdl/shconv_checker.sv */
// ----------------------------------------------------------------------------
// shconv_checker
// port-level checks of the sharpen convolution block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sharpen_convolution_rgba_assert.svh"

module shconv_checker import shconv_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [PIX_W-1:0] out_pixel_out,
  input wire logic             out_last_pixel
);

  // reset leaves the block idle with no result pending
  `SHCONV_ASSERT_ALL(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "not idle after reset")

  // one transaction at a time: the block is busy right after taking one
  `SHCONV_ASSERT_RUN(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "accepted back to back")

  // a new result only appears out of a busy period
  `SHCONV_ASSERT_RUN(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result while idle")

  // a stalled result holds
  `SHCONV_ASSERT_RUN(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_pixel_out) && $stable(out_last_pixel), "stalled result changed")

endmodule

bind sharpen_convolution_rgba shconv_checker u_shconv_checker (.*);

`default_nettype wire
